/* hdl/bpsm_pkg.sv */
package bpsm_pkg;

	// Default pool size and the fixed disk size.
	localparam int SLOT_COUNT_DEF   = 32;
	localparam int DISK_BLOCK_COUNT = 8192;

	// Field widths.
	localparam int ACTION_W = 2;
	localparam int BLOCK_W  = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 5;
	localparam int AGE_W    = 8;

	localparam logic [AGE_W-1:0] AGE_MAX = '1;

	// Request actions. The unused code behaves as a look-up.
	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_DIRTY  = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOB  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

	// One metadata RAM word per slot.
	typedef struct packed {
		logic               dirty;
		logic [AGE_W-1:0]   age;
		logic [BLOCK_W-1:0] block;
	} meta_t;

	// Control from the sequencer to the scan tracker.
	typedef struct packed {
		logic start;
		logic step;
		logic alloc;
	} trk_ctl_t;

	// Summary of a completed scan.
	typedef struct packed {
		logic               free_found;
		logic               best_dirty;
		logic [BLOCK_W-1:0] best_block;
		logic               hit;
		logic [AGE_W-1:0]   hit_age;
	} trk_res_t;

endpackage

/* hdl/bpsm_meta_store.sv */
module bpsm_meta_store #(
	parameter int SLOT_COUNT = bpsm_pkg::SLOT_COUNT_DEF,
	localparam int IW = $clog2(SLOT_COUNT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [IW-1:0]       rd_addr,
	output logic                rd_used,
	output bpsm_pkg::meta_t     rd_data,
	input  logic                wr_en,
	input  logic                wr_set_used,
	input  logic [IW-1:0]       wr_addr,
	input  bpsm_pkg::meta_t     wr_data
);

	// Slot metadata RAM; contents are undefined until a slot is first taken.
	bpsm_pkg::meta_t mem [SLOT_COUNT];
	bpsm_pkg::meta_t raw_q;
	logic            used_rd_q;

	// Occupancy valid bits, cleared by reset.
	logic [SLOT_COUNT-1:0] used_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			used_rd_q <= 1'b0;
		end else begin
			if (wr_en && wr_set_used) begin
				used_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				used_rd_q <= used_q[rd_addr];
			end
		end
	end

	// A free slot reads as its reset value: clean, age zero.
	assign rd_used = used_rd_q;
	assign rd_data = used_rd_q ? raw_q : '0;

endmodule

/* hdl/bpsm_tracker.sv */
module bpsm_tracker #(
	parameter int SLOT_COUNT = bpsm_pkg::SLOT_COUNT_DEF,
	localparam int IW = $clog2(SLOT_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bpsm_pkg::trk_ctl_t            ctl,
	input  logic [IW-1:0]                 idx,
	input  logic                          used,
	input  bpsm_pkg::meta_t               meta,
	input  logic [bpsm_pkg::BLOCK_W-1:0]  blk,
	output logic                          aged_we,
	output bpsm_pkg::meta_t               aged,
	output bpsm_pkg::trk_res_t            res,
	output logic [IW-1:0]                 free_idx,
	output logic [IW-1:0]                 best_idx,
	output logic [IW-1:0]                 hit_idx
);

	logic                         free_found_q;
	logic                         hit_q;
	logic [IW-1:0]                free_idx_q;
	logic [IW-1:0]                best_idx_q;
	logic [IW-1:0]                hit_idx_q;
	logic [bpsm_pkg::AGE_W-1:0]   best_age_q;
	logic                         best_dirty_q;
	logic [bpsm_pkg::BLOCK_W-1:0] best_block_q;
	logic [bpsm_pkg::AGE_W-1:0]   hit_age_q;
	logic                         older;
	logic                         match;

	// Saturating age step for an occupied slot.
	always_comb begin
		aged = meta;
		if (used && meta.age != bpsm_pkg::AGE_MAX) begin
			aged.age = meta.age + 1'b1;
		end
	end

	assign aged_we = ctl.step && ctl.alloc && used;

	// Strict compare keeps the lowest index among equally old slots.
	assign older = (idx == '0) || (aged.age > best_age_q);
	assign match = used && (meta.block == blk);

	// Control flags of the running scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
		end else if (ctl.start) begin
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
		end else if (ctl.step) begin
			if (!used) begin
				free_found_q <= 1'b1;
			end
			if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Candidate payload captured as entries go by.
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (!used && !free_found_q) begin
				free_idx_q <= idx;
			end
			if (older) begin
				best_idx_q   <= idx;
				best_age_q   <= aged.age;
				best_dirty_q <= meta.dirty;
				best_block_q <= meta.block;
			end
			if (match && !hit_q) begin
				hit_idx_q <= idx;
				hit_age_q <= meta.age;
			end
		end
	end

	assign res.free_found = free_found_q;
	assign res.best_dirty = best_dirty_q;
	assign res.best_block = best_block_q;
	assign res.hit        = hit_q;
	assign res.hit_age    = hit_age_q;
	assign free_idx       = free_idx_q;
	assign best_idx       = best_idx_q;
	assign hit_idx        = hit_idx_q;

endmodule

/* hdl/buffer_pool_slot_manager_top.sv */
// Channel | Handshake            | Payload
// request | in_valid / in_stall  | action, block_num
// result  | out_valid / out_stall| status, slot_index, writeback_needed, writeback_block
//
// An in-range request scans every slot before the next request is accepted;
// the metadata RAM is read one slot per cycle during the scan.
// An out-of-range request skips the scan and touches no slot metadata.
// Reset clears the occupancy bits at once; no clearing pass is needed.
// A stalled result holds the block in its final state; the RAM update for
// that request is made when the result moves into the output register.
module buffer_pool_slot_manager_top #(
	parameter int SLOT_COUNT = bpsm_pkg::SLOT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bpsm_pkg::ACTION_W-1:0]  action,
	input  logic [bpsm_pkg::BLOCK_W-1:0]   block_num,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bpsm_pkg::STATUS_W-1:0]  status,
	output logic [bpsm_pkg::SLOT_W-1:0]    slot_index,
	output logic                           writeback_needed,
	output logic [bpsm_pkg::BLOCK_W-1:0]   writeback_block
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t                          state_q;
	logic [bpsm_pkg::ACTION_W-1:0]   act_q;
	logic [bpsm_pkg::BLOCK_W-1:0]    blk_q;
	logic                            oob_q;
	logic                            issue_q;
	logic [IW-1:0]                   rd_idx_q;
	logic                            vld_s1;
	logic [IW-1:0]                   idx_s1;
	logic                            out_valid_q;
	logic [bpsm_pkg::STATUS_W-1:0]   status_q;
	logic [bpsm_pkg::SLOT_W-1:0]     slot_q;
	logic                            wb_q;
	logic [bpsm_pkg::BLOCK_W-1:0]    wb_blk_q;

	logic                            accept;
	logic                            in_oob;
	logic                            out_free;
	logic                            done_fire;
	logic                            is_alloc;
	logic                            rd_used;
	bpsm_pkg::meta_t                 rd_data;
	logic                            wr_en;
	logic                            wr_set_used;
	logic [IW-1:0]                   wr_addr;
	bpsm_pkg::meta_t                 wr_data;
	bpsm_pkg::trk_ctl_t              trk_ctl;
	logic                            aged_we;
	bpsm_pkg::meta_t                 aged;
	bpsm_pkg::trk_res_t              trk_res;
	logic [IW-1:0]                   free_idx;
	logic [IW-1:0]                   best_idx;
	logic [IW-1:0]                   hit_idx;
	logic [IW-1:0]                   pick;

	// Handshake decode.
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_oob    = {1'b0, block_num} >= 17'(bpsm_pkg::DISK_BLOCK_COUNT);
	assign out_free  = !out_valid_q || !out_stall;
	assign done_fire = (state_q == S_DONE) && out_free;
	assign is_alloc  = (act_q == bpsm_pkg::ACT_ALLOC);
	assign pick      = trk_res.free_found ? free_idx : best_idx;

	assign trk_ctl.start = accept;
	assign trk_ctl.step  = vld_s1;
	assign trk_ctl.alloc = is_alloc;

	// RAM write port: aging during the scan, the final update at the end.
	always_comb begin
		wr_en       = 1'b0;
		wr_set_used = 1'b0;
		wr_addr     = idx_s1;
		wr_data     = aged;
		if (aged_we) begin
			wr_en = 1'b1;
		end else if (done_fire && !oob_q) begin
			if (is_alloc) begin
				wr_en         = 1'b1;
				wr_set_used   = 1'b1;
				wr_addr       = pick;
				wr_data.dirty = 1'b0;
				wr_data.age   = '0;
				wr_data.block = blk_q;
			end else if (trk_res.hit && act_q == bpsm_pkg::ACT_DIRTY) begin
				wr_en         = 1'b1;
				wr_addr       = hit_idx;
				wr_data.dirty = 1'b1;
				wr_data.age   = trk_res.hit_age;
				wr_data.block = blk_q;
			end
		end
	end

	bpsm_meta_store #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_en       (issue_q),
		.rd_addr     (rd_idx_q),
		.rd_used     (rd_used),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_set_used (wr_set_used),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data)
	);

	bpsm_tracker #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_tracker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (trk_ctl),
		.idx      (idx_s1),
		.used     (rd_used),
		.meta     (rd_data),
		.blk      (blk_q),
		.aged_we  (aged_we),
		.aged     (aged),
		.res      (trk_res),
		.free_idx (free_idx),
		.best_idx (best_idx),
		.hit_idx  (hit_idx)
	);

	// Request payload latched at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			blk_q <= block_num;
			oob_q <= in_oob;
		end
	end

	// Sequencer, scan pipeline and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_q     <= 1'b0;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= bpsm_pkg::ST_OK;
			slot_q      <= '0;
			wb_q        <= 1'b0;
			wb_blk_q    <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= issue_q;
			idx_s1 <= rd_idx_q;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						if (in_oob) begin
							state_q <= S_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue_q) begin
						if (rd_idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + 1'b1;
						end
					end
					if (vld_s1 && idx_s1 == LAST_IDX) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						status_q    <= bpsm_pkg::ST_OK;
						slot_q      <= '0;
						wb_q        <= 1'b0;
						wb_blk_q    <= '0;
						if (oob_q) begin
							status_q <= bpsm_pkg::ST_OOB;
						end else if (is_alloc) begin
							slot_q <= bpsm_pkg::SLOT_W'(pick);
							if (!trk_res.free_found && trk_res.best_dirty) begin
								wb_q     <= 1'b1;
								wb_blk_q <= trk_res.best_block;
							end
						end else if (trk_res.hit) begin
							slot_q <= bpsm_pkg::SLOT_W'(hit_idx);
						end else begin
							status_q <= bpsm_pkg::ST_MISS;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign slot_index       = slot_q;
	assign writeback_needed = wb_q;
	assign writeback_block  = wb_blk_q;

`ifndef SYNTHESIS
	// The scan write-back never hits the entry being read in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && issue_q) |-> (wr_addr != rd_idx_q))
		else $error("metadata write collides with a scan read");

	// A result appears only as the sequencer leaves its final state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result raised outside the final state");

	// A write-back is reported only with a successful allocation.
	a_wb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && wb_q) |-> (status_q == bpsm_pkg::ST_OK))
		else $error("write-back reported with a failing status");

	// The last entry of the scan ends the scan.
	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && vld_s1 && idx_s1 == LAST_IDX) |=> (state_q == S_DONE))
		else $error("scan did not finish after the last slot");
`endif

endmodule

/* tb/sv/buffer_pool_slot_manager_top_test.sv */
`timescale 1ns / 100ps

module buffer_pool_slot_manager_top_test;
	import bpsm_pkg::*;

	localparam int NUM_SLOTS    = SLOT_COUNT_DEF;
	localparam int RANDOM_REQS  = 750;
	localparam int MAX_WAIT     = 17;
	localparam int CALM_SPAN    = 40;
	localparam int HOT_BLOCKS   = 40;
	localparam int REPORT_LIMIT = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int NUM_DIRECTED = 20;

	// The package names no code for the spare action; it acts as a look-up.
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic                wb;
		logic [BLOCK_W-1:0]  wb_block;
	} reply_t;

	typedef struct {
		logic [ACTION_W-1:0] act;
		logic [BLOCK_W-1:0]  blk;
		bit                  typed;
		reply_t              reply;
	} dir_row_t;

	localparam reply_t MISS_REPLY = '{ST_MISS, 5'd0, 1'b0, 16'd0};
	localparam reply_t OOB_REPLY  = '{ST_OOB, 5'd0, 1'b0, 16'd0};
	localparam reply_t NO_REPLY   = '0;

	// Directed requests. Rows with a typed reply are checked against it;
	// the others are checked against the pool predictor.
	dir_row_t directed_rows [NUM_DIRECTED] = '{
		'{ACT_LOOKUP, 16'd0,      1'b1, MISS_REPLY},
		'{ACT_DIRTY,  16'd8191,   1'b1, MISS_REPLY},
		'{ACT_SPARE,  16'd100,    1'b1, MISS_REPLY},
		'{ACT_ALLOC,  16'd8192,   1'b1, OOB_REPLY},
		'{ACT_ALLOC,  16'hFFFF,   1'b1, OOB_REPLY},
		'{ACT_LOOKUP, 16'hA000,   1'b1, OOB_REPLY},
		'{ACT_DIRTY,  16'h5FFF,   1'b1, OOB_REPLY},
		'{ACT_ALLOC,  16'd0,      1'b1, '{ST_OK, 5'd0, 1'b0, 16'd0}},
		'{ACT_ALLOC,  16'd8191,   1'b1, '{ST_OK, 5'd1, 1'b0, 16'd0}},
		'{ACT_ALLOC,  16'd0,      1'b1, '{ST_OK, 5'd2, 1'b0, 16'd0}},
		'{ACT_LOOKUP, 16'd0,      1'b1, '{ST_OK, 5'd0, 1'b0, 16'd0}},
		'{ACT_DIRTY,  16'd0,      1'b1, '{ST_OK, 5'd0, 1'b0, 16'd0}},
		'{ACT_SPARE,  16'd8191,   1'b1, '{ST_OK, 5'd1, 1'b0, 16'd0}},
		'{ACT_LOOKUP, 16'd8190,   1'b1, MISS_REPLY},
		'{ACT_ALLOC,  16'h1555,   1'b0, NO_REPLY},
		'{ACT_ALLOC,  16'h0AAA,   1'b0, NO_REPLY},
		'{ACT_DIRTY,  16'h0AAA,   1'b0, NO_REPLY},
		'{ACT_LOOKUP, 16'h1555,   1'b0, NO_REPLY},
		'{ACT_ALLOC,  16'd8192,   1'b1, OOB_REPLY},
		'{ACT_DIRTY,  16'd8191,   1'b0, NO_REPLY}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [ACTION_W-1:0] action;
	logic [BLOCK_W-1:0]  block_num;
	logic                out_valid;
	logic                out_stall;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot_index;
	logic                writeback_needed;
	logic [BLOCK_W-1:0]  writeback_block;

	// Shadow copy of the slot metadata table.
	bit             pool_used  [NUM_SLOTS];
	bit             pool_dirty [NUM_SLOTS];
	bit [BLOCK_W-1:0] pool_block [NUM_SLOTS];
	bit [AGE_W-1:0]   pool_age   [NUM_SLOTS];

	reply_t         pending_replies [$];
	reply_t         oldest_reply;
	logic [BLOCK_W-1:0] hot_blocks [HOT_BLOCKS];
	bit             send_calm;
	int             fail_count;
	int             cycle_count;

	buffer_pool_slot_manager_top #(
		.SLOT_COUNT(NUM_SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.block_num(block_num),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.slot_index(slot_index),
		.writeback_needed(writeback_needed),
		.writeback_block(writeback_block)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Works out the reply to one request and updates the shadow table.
	function automatic reply_t predict_reply(input logic [ACTION_W-1:0] act,
			input logic [BLOCK_W-1:0] blk);
		reply_t r;
		int i;
		int pick;
		int hit;
		r = NO_REPLY;
		r.status = ST_OK;
		if (blk >= DISK_BLOCK_COUNT) begin
			r.status = ST_OOB;
		end else if (act == ACT_ALLOC) begin
			// Age every occupied slot, saturating at the top.
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (pool_used[i] && pool_age[i] != AGE_MAX)
					pool_age[i] = pool_age[i] + 1'b1;
			end
			pick = -1;
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (!pool_used[i] && pick < 0)
					pick = i;
			end
			// No free slot: evict the oldest, the lowest index winning ties.
			if (pick < 0) begin
				pick = 0;
				for (i = 1; i < NUM_SLOTS; i++) begin
					if (pool_age[i] > pool_age[pick])
						pick = i;
				end
				if (pool_dirty[pick]) begin
					r.wb = 1'b1;
					r.wb_block = pool_block[pick];
				end
			end
			pool_used[pick]  = 1'b1;
			pool_dirty[pick] = 1'b0;
			pool_block[pick] = blk;
			pool_age[pick]   = '0;
			r.slot = pick[SLOT_W-1:0];
		end else begin
			// Look-up, mark dirty and the spare code use the lowest match.
			hit = -1;
			for (i = 0; i < NUM_SLOTS; i++) begin
				if (pool_used[i] && pool_block[i] == blk && hit < 0)
					hit = i;
			end
			if (hit < 0) begin
				r.status = ST_MISS;
			end else begin
				if (act == ACT_DIRTY)
					pool_dirty[hit] = 1'b1;
				r.slot = hit[SLOT_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic void report_failure(input string msg);
		if (fail_count < REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
		fail_count++;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want)
			report_failure($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
	endfunction

	// Presents one request beat, after a random gap unless traffic is calm, and
	// records its reply once the beat is taken.
	task automatic send_request(input logic [ACTION_W-1:0] act,
			input logic [BLOCK_W-1:0] blk, input bit typed, input reply_t typed_reply);
		int gap;
		reply_t predicted;
		gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		block_num <= blk;
		do @(posedge clk); while (in_stall);
		predicted = predict_reply(act, blk);
		pending_replies.push_back(typed ? typed_reply : predicted);
		@(negedge clk);
	endtask

	// Result side: stall for a random count before taking each beat, unless calm.
	initial begin
		int n;
		int served;
		bit calm;
		out_stall = 1'b0;
		served = 0;
		calm = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (served % CALM_SPAN == 0)
				calm = ($urandom_range(0, 3) == 0);
			n = calm ? 0 : $urandom_range(0, MAX_WAIT);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			served++;
			@(negedge clk);
		end
	end

	// Compare every taken result beat with the oldest outstanding reply.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				report_failure($sformatf("unexpected result: status %0d slot %0d",
					status, slot_index));
			end else begin
				oldest_reply = pending_replies.pop_front();
				check_field("status", 32'(oldest_reply.status), 32'(status));
				check_field("slot_index", 32'(oldest_reply.slot), 32'(slot_index));
				check_field("writeback_needed", 32'(oldest_reply.wb),
					32'(writeback_needed));
				check_field("writeback_block", 32'(oldest_reply.wb_block),
					32'(writeback_block));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int i;
		int r;
		logic [ACTION_W-1:0] act;
		logic [BLOCK_W-1:0] blk;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ALLOC;
		block_num = '0;
		send_calm = 1'b0;
		fail_count = 0;
		cycle_count = 0;

		// A small set of popular blocks, larger than the pool, so that
		// hits, misses and evictions all happen often.
		hot_blocks[0] = '0;
		hot_blocks[1] = BLOCK_W'(DISK_BLOCK_COUNT - 1);
		for (i = 2; i < HOT_BLOCKS; i++)
			hot_blocks[i] = BLOCK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < NUM_DIRECTED; i++)
			send_request(directed_rows[i].act, directed_rows[i].blk,
				directed_rows[i].typed, directed_rows[i].reply);

		// Random traffic: mostly allocations and hits on popular blocks,
		// with some wide block numbers that often fall out of range.
		for (i = 0; i < RANDOM_REQS; i++) begin
			if (i % CALM_SPAN == 0)
				send_calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 45)
				act = ACT_ALLOC;
			else if (r < 70)
				act = ACT_LOOKUP;
			else if (r < 92)
				act = ACT_DIRTY;
			else
				act = ACT_SPARE;
			r = $urandom_range(0, 99);
			if (r < 70)
				blk = hot_blocks[$urandom_range(0, HOT_BLOCKS - 1)];
			else if (r < 90)
				blk = BLOCK_W'($urandom_range(0, DISK_BLOCK_COUNT - 1));
			else
				blk = BLOCK_W'($urandom);
			send_request(act, blk, 1'b0, NO_REPLY);
		end
		in_valid <= 1'b0;

		// Drain, then give the block time to show any stray beat.
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (2 * NUM_SLOTS + 8) @(posedge clk);

		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
hdl/bpsm_pkg.sv
hdl/bpsm_meta_store.sv
hdl/bpsm_tracker.sv
hdl/buffer_pool_slot_manager_top.sv
tb/sv/buffer_pool_slot_manager_top_test.sv
